@@ rtl/cwrr_pkg.sv @@
// Package for the credit weighted round robin block.
// Holds field widths, command and status codes, the sequencer states and defaults.
// No dependencies.
`default_nettype none

package cwrr_pkg;

  localparam int CMD_W     = 2;
  localparam int MODEL_W   = 4;
  localparam int DEV_W     = 5;
  localparam int SHARE_W   = 7;
  localparam int REP_W     = 3;
  localparam int TP_W      = 24;
  localparam int KEY_W     = MODEL_W + DEV_W + SHARE_W + REP_W;
  localparam int STRIDE_W  = 41;
  localparam int CREDIT_W  = 48;
  localparam int STATUS_W  = 2;
  localparam int ENTRY_W   = KEY_W + STRIDE_W + CREDIT_W;
  localparam int MODEL_NUM = 1 << MODEL_W;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int MODEL_COUNT_DEF   = 16;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ZERO_TP = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_MISS    = 2'd3;

  // 10.0 in Q16.32
  localparam logic [CREDIT_W-1:0] MARK_INIT = 48'h000A_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } cwrr_state_t;

endpackage

`default_nettype wire

@@ rtl/cwrr_if.sv @@
// Request and result channel interfaces of the credit weighted round robin block.
// Depends on cwrr_pkg for field widths.
`default_nettype none

interface cwrr_in_if;
  import cwrr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [MODEL_W-1:0]   model_index;
  logic [DEV_W-1:0]     device_index;
  logic [SHARE_W-1:0]   share_percent;
  logic [REP_W-1:0]     replica_index;
  logic [TP_W-1:0]      throughput;

  modport source (output valid, command, model_index, device_index, share_percent,
                  replica_index, throughput, input ready);
  modport sink (input valid, command, model_index, device_index, share_percent,
                replica_index, throughput, output ready);
endinterface

interface cwrr_out_if;
  import cwrr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 grant;
  logic [STATUS_W-1:0]  status;
  logic [CREDIT_W-1:0]  credit_after;

  modport source (output valid, grant, status, credit_after, input ready);
  modport sink (input valid, grant, status, credit_after, output ready);
endinterface

`default_nettype wire

@@ rtl/cwrr_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module cwrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/cwrr_div.sv @@
// Restoring bit-serial divider computing floor(2^40 / divisor), one quotient bit a cycle.
// Depends on cwrr_pkg for widths.
`default_nettype none

module cwrr_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [cwrr_pkg::TP_W-1:0]      divisor,
  output logic                                done,
  output logic      [cwrr_pkg::STRIDE_W-1:0]  quotient
);
  import cwrr_pkg::*;

  localparam int CNT_W = $clog2(STRIDE_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [TP_W-1:0]     rem_r, rem_nxt;
  logic [STRIDE_W-1:0] q_r, q_nxt;
  logic [TP_W:0]       trial;

  // The dividend is a single one in its top bit, so the first shifted-in bit is one.
  assign trial = {rem_r, (cnt_r == '0)};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = TP_W'(trial - {1'b0, divisor});
        q_nxt   = {q_r[STRIDE_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[TP_W-1:0];
        q_nxt   = {q_r[STRIDE_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STRIDE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

@@ rtl/credit_weighted_round_robin_top.sv @@
// Credit weighted round robin dispatch table. One request at a time; in_if.ready is low
// from accept until the result is taken. Clear, disabled or zero-throughput requests
// skip the search; an insert that hits or finds room then runs the bit-serial reciprocal
// divider. The key search reads the entry RAM one entry at a time, in the read and
// compare states. Synchronous active-low reset empties the table (fill count zero) and
// clears balancing_enabled; no clearing pass is needed.
`default_nettype none

module credit_weighted_round_robin_top #(
  parameter int TABLE_ENTRIES = cwrr_pkg::TABLE_ENTRIES_DEF,
  parameter int MODEL_COUNT   = cwrr_pkg::MODEL_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  cwrr_in_if.sink          in_if,
  cwrr_out_if.source       out_if,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import cwrr_pkg::*;

  localparam int AW = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int MW = MODEL_COUNT > 1 ? $clog2(MODEL_COUNT) : 1;

  cwrr_state_t          state_r, state_nxt;
  logic                 bal_r;
  logic [CMD_W-1:0]     cmd_r;
  logic [MODEL_W-1:0]   model_r;
  logic [KEY_W-1:0]     key_r;
  logic [TP_W-1:0]      tp_r;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 new_r, new_nxt;
  logic                 grant_r, grant_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [CREDIT_W-1:0]  credit_r, credit_nxt;
  logic                 out_vld_r, out_vld_nxt;

  logic                 in_acc;
  logic                 div_start, div_done;
  logic [STRIDE_W-1:0]  div_q;

  logic                 e_we;
  logic [ENTRY_W-1:0]   e_wdata, e_rdata;
  logic [KEY_W-1:0]     e_key;
  logic [STRIDE_W-1:0]  e_stride;
  logic [CREDIT_W-1:0]  e_credit;
  logic                 m_we;
  logic [CREDIT_W-1:0]  m_wdata, m_rdata;
  logic [MW-1:0]        midx_lut [MODEL_NUM];
  logic [CREDIT_W:0]    sum;
  logic [CREDIT_W-1:0]  sum_sat;
  logic                 key_hit, at_end, has_room;

  for (genvar g = 0; g < MODEL_NUM; g++) begin : g_midx
    assign midx_lut[g] = MW'(g % MODEL_COUNT);
  end

  assign in_acc   = in_if.valid && in_if.ready;
  assign {e_key, e_stride, e_credit} = e_rdata;
  assign key_hit  = (e_key == key_r);
  assign at_end   = (idx_r == count_r);
  assign has_room = (count_r < CW'(TABLE_ENTRIES));
  assign sum      = {1'b0, e_credit} + (CREDIT_W + 1)'(e_stride);
  assign sum_sat  = sum[CREDIT_W] ? '1 : sum[CREDIT_W-1:0];

  cwrr_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (idx_r[AW-1:0]),
    .wdata (e_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (e_rdata)
  );

  cwrr_ram #(.WIDTH(CREDIT_W), .DEPTH(MODEL_COUNT)) u_mark_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (midx_lut[model_r]),
    .wdata (m_wdata),
    .raddr (midx_lut[model_r]),
    .rdata (m_rdata)
  );

  cwrr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (tp_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (bal_r && (in_if.command == CMD_CHECK ||
                        (in_if.command == CMD_INSERT && in_if.throughput != '0))) begin
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_RD: begin
        if (!at_end) begin
          state_nxt = ST_CMP;
        end else if (cmd_r == CMD_INSERT && has_room) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_CMP: begin
        if (!key_hit) begin
          state_nxt = ST_RD;
        end else if (cmd_r == CMD_CHECK) begin
          state_nxt = ST_UPD;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_UPD:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_if.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    new_nxt     = new_r;
    grant_nxt   = grant_r;
    status_nxt  = status_r;
    credit_nxt  = credit_r;
    out_vld_nxt = out_vld_r;
    div_start   = 1'b0;
    e_we        = 1'b0;
    e_wdata     = {key_r, div_q, {CREDIT_W{1'b0}}};
    m_we        = 1'b0;
    m_wdata     = MARK_INIT;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt    = '0;
          grant_nxt  = 1'b0;
          status_nxt = STAT_OK;
          credit_nxt = '0;
          if (!bal_r) begin
            grant_nxt = (in_if.command == CMD_CHECK);
          end else if (in_if.command == CMD_CLEAR) begin
            count_nxt = '0;
          end else if (in_if.command == CMD_INSERT && in_if.throughput == '0) begin
            status_nxt = STAT_ZERO_TP;
          end
          if (!bal_r || in_if.command == CMD_CLEAR || !(in_if.command == CMD_CHECK ||
              (in_if.command == CMD_INSERT && in_if.throughput != '0))) begin
            out_vld_nxt = 1'b1;
          end
        end
      end
      ST_RD: begin
        if (at_end) begin
          if (cmd_r == CMD_CHECK) begin
            status_nxt  = STAT_MISS;
            out_vld_nxt = 1'b1;
          end else if (has_room) begin
            new_nxt   = 1'b1;
            div_start = 1'b1;
          end else begin
            status_nxt  = STAT_FULL;
            out_vld_nxt = 1'b1;
          end
        end
      end
      ST_CMP: begin
        if (!key_hit) begin
          idx_nxt = idx_r + 1'b1;
        end else if (cmd_r == CMD_INSERT) begin
          new_nxt   = 1'b0;
          div_start = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          e_we        = 1'b1;
          m_we        = 1'b1;
          out_vld_nxt = 1'b1;
          if (new_r) begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      ST_UPD: begin
        out_vld_nxt = 1'b1;
        credit_nxt  = e_credit;
        if (e_credit <= m_rdata) begin
          e_we       = 1'b1;
          e_wdata    = {e_key, e_stride, sum_sat};
          m_we       = 1'b1;
          m_wdata    = sum_sat;
          grant_nxt  = 1'b1;
          credit_nxt = sum_sat;
        end
      end
      ST_OUT: begin
        if (out_if.ready) begin
          out_vld_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bal_r     <= 1'b0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
        bal_r <= cfg_pwdata[0];
      end
    end
    idx_r    <= idx_nxt;
    new_r    <= new_nxt;
    grant_r  <= grant_nxt;
    status_r <= status_nxt;
    credit_r <= credit_nxt;
    if (in_acc) begin
      cmd_r   <= in_if.command;
      model_r <= in_if.model_index;
      key_r   <= {in_if.model_index, in_if.device_index, in_if.share_percent,
                  in_if.replica_index};
      tp_r    <= in_if.throughput;
    end
  end

  assign in_if.ready         = (state_r == ST_IDLE);
  assign out_if.valid        = out_vld_r;
  assign out_if.grant        = grant_r;
  assign out_if.status       = status_r;
  assign out_if.credit_after = credit_r;
  assign cfg_pready          = 1'b1;
  assign cfg_prdata          = cfg_paddr[2] ? 32'd0 : {31'd0, bal_r};

endmodule

`default_nettype wire

@@ rtl/cwrr_checker.sv @@
// Port-level checker for the credit weighted round robin top level, with its bind.
// Depends on cwrr_pkg and credit_weighted_round_robin_top.
`default_nettype none

module cwrr_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic                           grant,
  input wire logic [cwrr_pkg::STATUS_W-1:0]  status,
  input wire logic [cwrr_pkg::CREDIT_W-1:0]  credit_after
);
  import cwrr_pkg::*;

  // Hold a pending result and its payload until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({grant, status, credit_after}))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken while one is in flight");

  a_no_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request side open while result pending");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && grant |-> status == STAT_OK)
    else $error("grant with error status");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STAT_OK |-> credit_after == '0 && !grant)
    else $error("error result carries credit");

endmodule

bind credit_weighted_round_robin_top cwrr_checker u_cwrr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .grant        (out_if.grant),
  .status       (out_if.status),
  .credit_after (out_if.credit_after)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for credit_weighted_round_robin_top.
// Runs a directed table, a table fill, a credit saturation run and random traffic,
// each result checked against the predictor or a typed row. Depends on cwrr_pkg and cwrr_if.
`default_nettype none

module tb_top;
  import cwrr_pkg::*;

  localparam int SLOTS      = TABLE_ENTRIES_DEF;
  localparam int MODELS     = MODEL_COUNT_DEF;
  localparam int CYCLE_CAP  = 1500000;
  localparam int LONG_HOLD  = 400;
  localparam int SETTLE     = 200;
  localparam logic [CREDIT_W-1:0] CREDIT_MAX = {CREDIT_W{1'b1}};
  localparam logic [2:0] REG_BALANCING = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [MODEL_W-1:0] model;
    logic [DEV_W-1:0]   dev;
    logic [SHARE_W-1:0] share;
    logic [REP_W-1:0]   rep;
    logic [TP_W-1:0]    tp;
  } request_t;

  typedef struct packed {
    logic                grant;
    logic [STATUS_W-1:0] status;
    logic [CREDIT_W-1:0] credit;
  } decision_t;

  typedef struct packed {
    logic      balancing;
    request_t  req;
    logic      typed;
    decision_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  cwrr_in_if  req_ch();
  cwrr_out_if res_ch();

  credit_weighted_round_robin_top dut (
    .clk(clk), .rst_n(rst_n), .in_if(req_ch.sink), .out_if(res_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic                balancing_on;
  logic                slot_used [SLOTS];
  logic [KEY_W-1:0]    slot_key [SLOTS];
  logic [STRIDE_W-1:0] slot_stride [SLOTS];
  logic [CREDIT_W-1:0] slot_credit [SLOTS];
  logic [CREDIT_W-1:0] model_mark [MODELS];
  int                  fill_count;

  decision_t pending_results[$];
  int  errors = 0;
  int  checked = 0;
  int  grants_seen = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_request = 1'b0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, checked);
    errors++;
  endtask

  function automatic void wipe_dispatch();
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    for (int m = 0; m < MODELS; m++) model_mark[m] = '0;
    fill_count = 0;
  endfunction

  function automatic int lookup_slot(logic [KEY_W-1:0] key);
    for (int i = 0; i < fill_count && i < SLOTS; i++)
      if (slot_used[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  function automatic decision_t dispatch_predict(request_t r);
    decision_t d;
    logic [KEY_W-1:0] key;
    int slot;
    int midx;
    logic [CREDIT_W:0] sum;
    d = '0;
    key = {r.model, r.dev, r.share, r.rep};
    midx = int'(r.model) % MODELS;
    if (r.cmd == CMD_CHECK) begin
      if (!balancing_on) begin
        d.grant = 1'b1;
      end else begin
        slot = lookup_slot(key);
        if (slot < 0) begin
          d.status = STAT_MISS;
        end else begin
          d.credit = slot_credit[slot];
          if (d.credit <= model_mark[midx]) begin
            sum = {1'b0, d.credit} + (CREDIT_W + 1)'(slot_stride[slot]);
            d.credit = sum[CREDIT_W] ? CREDIT_MAX : sum[CREDIT_W-1:0];
            slot_credit[slot] = d.credit;
            model_mark[midx] = d.credit;
            d.grant = 1'b1;
          end
        end
      end
    end else if (r.cmd == CMD_CLEAR && balancing_on) begin
      wipe_dispatch();
    end else if (r.cmd == CMD_INSERT && balancing_on) begin
      if (r.tp == '0) begin
        d.status = STAT_ZERO_TP;
      end else begin
        slot = lookup_slot(key);
        if (slot < 0 && fill_count < SLOTS) begin
          slot = fill_count;
          fill_count++;
        end
        if (slot < 0) begin
          d.status = STAT_FULL;
        end else begin
          slot_used[slot] = 1'b1;
          slot_key[slot] = key;
          slot_stride[slot] = STRIDE_W'((64'd1 << 40) / 64'(r.tp));
          slot_credit[slot] = '0;
          model_mark[midx] = MARK_INIT;
        end
      end
    end
    return d;
  endfunction

  // result checker
  always @(posedge clk) begin
    decision_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'({res_ch.grant, res_ch.status}), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.grant !== want.grant)
          report_mismatch("grant", 64'(res_ch.grant), 64'(want.grant));
        if (res_ch.status !== want.status)
          report_mismatch("status", 64'(res_ch.status), 64'(want.status));
        if (res_ch.credit_after !== want.credit)
          report_mismatch("credit_after", 64'(res_ch.credit_after), 64'(want.credit));
        if (res_ch.grant === 1'b1) grants_seen++;
      end
      checked++;
    end
  end

  // result stalls: random bursts, one long hold-off on request
  initial begin
    int n;
    res_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        res_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("credit_weighted_round_robin_top test failed");
      $finish;
    end
  end

  // offer one request; expectation is recorded at the accepting edge
  task automatic send_request(request_t r, logic typed = 1'b0, decision_t want = '0);
    decision_t d;
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 8);
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.command       <= r.cmd;
    req_ch.model_index   <= r.model;
    req_ch.device_index  <= r.dev;
    req_ch.share_percent <= r.share;
    req_ch.replica_index <= r.rep;
    req_ch.throughput    <= r.tp;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    d = dispatch_predict(r);
    pending_results = {pending_results, (typed ? want : d)};
  endtask

  // lower valid and wait until every result has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_balancing(logic on);
    drain();
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= REG_BALANCING;
    cfg_pwdata <= {31'd0, on};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    balancing_on = on;
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
    if (cfg_prdata !== {31'd0, on})
      report_mismatch("balancing_enabled readback", 64'(cfg_prdata), 64'(on));
  endtask

  function automatic request_t mk(logic [CMD_W-1:0] c, int m, int dv, int s, int rp, int t);
    request_t r;
    r.cmd = c; r.model = MODEL_W'(m); r.dev = DEV_W'(dv); r.share = SHARE_W'(s);
    r.rep = REP_W'(rp); r.tp = TP_W'(t);
    return r;
  endfunction

  function automatic decision_t dec(logic g, logic [STATUS_W-1:0] s);
    decision_t d;
    d.grant = g; d.status = s; d.credit = '0;
    return d;
  endfunction

  stim_row_t directed[] = '{
    '{1'b0, mk(CMD_CHECK, 3, 7, 50, 2, 0), 1'b1, dec(1'b1, STAT_OK)},
    '{1'b0, mk(CMD_INSERT, 1, 1, 1, 1, 256), 1'b1, dec(1'b0, STAT_OK)},
    '{1'b0, mk(CMD_NONE, 0, 0, 0, 0, 0), 1'b1, dec(1'b0, STAT_OK)},
    '{1'b0, mk(CMD_CLEAR, 0, 0, 0, 0, 0), 1'b1, dec(1'b0, STAT_OK)},
    '{1'b1, mk(CMD_CHECK, 0, 0, 0, 0, 0), 1'b1, dec(1'b0, STAT_MISS)},
    '{1'b1, mk(CMD_INSERT, 15, 31, 100, 7, 0), 1'b1, dec(1'b0, STAT_ZERO_TP)},
    '{1'b1, mk(CMD_INSERT, 15, 31, 100, 7, 24'hFFFFFF), 1'b1, dec(1'b0, STAT_OK)},
    '{1'b1, mk(CMD_CHECK, 15, 31, 100, 7, 0), 1'b0, dec(1'b0, STAT_OK)},
    '{1'b1, mk(CMD_INSERT, 0, 0, 0, 0, 1), 1'b1, dec(1'b0, STAT_OK)},
    '{1'b1, mk(CMD_CHECK, 0, 0, 0, 0, 0), 1'b0, dec(1'b0, STAT_OK)},
    '{1'b1, mk(CMD_CHECK, 0, 0, 0, 0, 0), 1'b0, dec(1'b0, STAT_OK)},
    '{1'b1, mk(CMD_INSERT, 0, 1, 0, 0, 256), 1'b1, dec(1'b0, STAT_OK)},
    '{1'b1, mk(CMD_CHECK, 0, 1, 0, 0, 0), 1'b0, dec(1'b0, STAT_OK)},
    '{1'b1, mk(CMD_CHECK, 0, 0, 0, 0, 0), 1'b0, dec(1'b0, STAT_OK)},
    '{1'b1, mk(CMD_INSERT, 0, 0, 0, 0, 2048), 1'b1, dec(1'b0, STAT_OK)},
    '{1'b1, mk(CMD_CHECK, 0, 0, 0, 0, 0), 1'b0, dec(1'b0, STAT_OK)},
    '{1'b1, mk(CMD_CHECK, 9, 16, 64, 4, 0), 1'b1, dec(1'b0, STAT_MISS)},
    '{1'b1, mk(CMD_NONE, 15, 31, 100, 7, 24'hFFFFFF), 1'b1, dec(1'b0, STAT_OK)},
    '{1'b1, mk(CMD_CLEAR, 0, 0, 0, 0, 0), 1'b1, dec(1'b0, STAT_OK)},
    '{1'b1, mk(CMD_CHECK, 15, 31, 100, 7, 0), 1'b1, dec(1'b0, STAT_MISS)},
    '{1'b0, mk(CMD_CHECK, 15, 31, 100, 7, 0), 1'b1, dec(1'b1, STAT_OK)}
  };

  function automatic request_t random_request(const ref request_t keys[$]);
    request_t r;
    int pick;
    int roll;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      r.model = MODEL_W'($urandom); r.dev = DEV_W'($urandom);
      r.share = SHARE_W'($urandom_range(0, 100)); r.rep = REP_W'($urandom);
    end else begin
      r = keys[$urandom_range(0, keys.size() - 1)];
    end
    roll = $urandom_range(0, 99);
    r.cmd = roll < 70 ? CMD_CHECK : roll < 94 ? CMD_INSERT : roll < 97 ? CMD_CLEAR : CMD_NONE;
    roll = $urandom_range(0, 9);
    r.tp = roll == 0 ? 24'd0 : roll < 4 ? TP_W'($urandom_range(1, 255)) : TP_W'($urandom);
    return r;
  endfunction

  initial begin
    request_t keys[$];
    request_t r;
    int n;
    req_ch.valid <= 1'b0;
    req_ch.command <= '0; req_ch.model_index <= '0; req_ch.device_index <= '0;
    req_ch.share_percent <= '0; req_ch.replica_index <= '0; req_ch.throughput <= '0;
    balancing_on = 1'b0;
    wipe_dispatch();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].balancing != balancing_on) set_balancing(directed[i].balancing);
      send_request(directed[i].req, directed[i].typed, directed[i].want);
    end

    // fill the table to the brim, then one new key must bounce
    set_balancing(1'b1);
    send_request(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
    for (int i = 0; i < SLOTS; i++)
      send_request(mk(CMD_INSERT, i % 16, i / 16, i, i % 8, $urandom_range(1, 24'hFFFFFF)));
    send_request(mk(CMD_INSERT, 5, 30, 99, 3, 100), 1'b1, dec(1'b0, STAT_FULL));
    send_request(mk(CMD_INSERT, 5, 0, 5, 5, 300));
    send_request(mk(CMD_CHECK, 15, 3, 63, 7, 0));

    // a lone slowest partition grants every time and climbs into saturation
    send_request(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
    send_request(mk(CMD_INSERT, 12, 9, 33, 6, 1));
    repeat (260) send_request(mk(CMD_CHECK, 12, 9, 33, 6, 0));

    // random phases over a small key pool so lookups mostly hit
    for (int phase = 0; phase < 9; phase++) begin
      keys.delete();
      n = $urandom_range(2, 14);
      repeat (n) begin
        r.model = MODEL_W'($urandom); r.dev = DEV_W'($urandom);
        r.share = SHARE_W'($urandom_range(0, 100));
        r.rep = REP_W'($urandom);
        keys = {keys, r};
      end
      if (phase == 8) quiet = 1'b1;
      set_balancing(phase == 2 || phase == 5 ? 1'b0 : 1'b1);
      if (phase == 3) hold_request = 1'b1;
      repeat (160) send_request(random_request(keys));
    end

    drain();
    n = 0;
    while (pending_results.size() != 0 && n < 1000) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE) @(posedge clk);
    $display("checked %0d results (%0d grants) over directed, fill, saturation and random",
             checked, grants_seen);
    $display("phases with balancing on and off; %0d mismatches", errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("credit_weighted_round_robin_top test passed");
    end else begin
      $display("credit_weighted_round_robin_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
